[hw/rtl/shsp_pkg.sv]
// Shared constants and types of the sample history strip plot.
`timescale 1ns / 1ps

package shsp_pkg;

  localparam int HistoryDepth = 50;
  localparam int PlotCeiling  = 40;

  localparam int AddrW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int CntW  = $clog2(HistoryDepth + 1);

  localparam int SampleW  = 13;
  localparam int DivW     = 8;
  localparam int OffsetW  = 8;
  localparam int OriginXW = 9;
  localparam int OriginYW = 8;
  localparam int ColourW  = 3;
  localparam int ColumnW  = 6;
  localparam int HeightW  = 6;

  // reciprocal floor(2^RecipK / d); RecipK >= SampleW keeps the estimate within one
  localparam int RecipK = SampleW;
  localparam int RecipW = RecipK + 1;
  localparam int RecipCntW = $clog2(RecipW);
  localparam int MagW   = SampleW;
  localparam int QuotW  = SampleW;
  localparam int ProdW  = MagW + RecipW;
  localparam int QdW    = QuotW + DivW;
  localparam int HsumW  = QuotW + 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  typedef enum logic [CfgIdxW-1:0] {
    RegDivisor = 3'd0,
    RegOffset  = 3'd1,
    RegOriginX = 3'd2,
    RegOriginY = 3'd3,
    RegColour  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CntW-1:0] column;
    logic            last;
  } pt_ctl_t;

endpackage

[hw/rtl/sample_history_strip_plot_top.sv]
// Top level of the sample history strip plot: history memory, divide pipeline, output stage.
`timescale 1ns / 1ps

// Sample history strip plot, one instance per sensor channel.
// Input channel: in_valid_i / in_stall_o with one signed 13-bit sample per item.
// Output channel: out_valid_o / out_stall_i; each input item yields one point
// per stored sample (up to 50), oldest first, last_point_o set on the newest.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i picks
// divisor, offset, origin x, origin y or colour; write only while idle.
// Per item: the divisor reciprocal is first formed in a bit-serial loop,
// then one history read per cycle while out_stall_i does not hold the
// pipeline (fill count reads), then five pipeline stages drain (read,
// multiply, back-multiply, correct, output reg). The single memory read
// port sets the one-point-per-cycle pace when the output is not stalled.
// in_stall_o is high from acceptance until the pipeline has emptied; the last
// point may still wait in the output register when the next item is taken.
// out_stall_i freezes the whole point pipeline; nothing is dropped.
// Reset empties the history (fill count zero) and loads the register defaults:
// divisor 1, offset 0, origin x 0, origin y 40, colour 4.

module sample_history_strip_plot_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [shsp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [shsp_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [shsp_pkg::SampleW-1:0] sample_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [shsp_pkg::ColumnW-1:0]       column_index_o,
  output logic [shsp_pkg::HeightW-1:0]       plot_height_o,
  output logic [shsp_pkg::OriginXW-1:0]      pixel_x_o,
  output logic [shsp_pkg::OriginYW-1:0]      pixel_y_o,
  output logic [shsp_pkg::ColourW-1:0]       pixel_colour_o,
  output logic                               last_point_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRecip,
    StRun,
    StDrain
  } state_e;

  localparam logic [shsp_pkg::AddrW-1:0] LastSlot = shsp_pkg::AddrW'(shsp_pkg::HistoryDepth - 1);
  localparam logic [shsp_pkg::CntW-1:0]  FullCnt  = shsp_pkg::CntW'(shsp_pkg::HistoryDepth);

  // configuration registers
  logic [shsp_pkg::DivW-1:0]            div_q;
  logic signed [shsp_pkg::OffsetW-1:0]  offset_q;
  logic [shsp_pkg::OriginXW-1:0]        origin_x_q;
  logic [shsp_pkg::OriginYW-1:0]        origin_y_q;
  logic [shsp_pkg::ColourW-1:0]         colour_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q      <= shsp_pkg::DivW'(1);
      offset_q   <= '0;
      origin_x_q <= '0;
      origin_y_q <= shsp_pkg::OriginYW'(40);
      colour_q   <= shsp_pkg::ColourW'(4);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        shsp_pkg::RegDivisor: div_q      <= cfg_data_i[shsp_pkg::DivW-1:0];
        shsp_pkg::RegOffset:  offset_q   <= cfg_data_i[shsp_pkg::OffsetW-1:0];
        shsp_pkg::RegOriginX: origin_x_q <= cfg_data_i[shsp_pkg::OriginXW-1:0];
        shsp_pkg::RegOriginY: origin_y_q <= cfg_data_i[shsp_pkg::OriginYW-1:0];
        shsp_pkg::RegColour:  colour_q   <= cfg_data_i[shsp_pkg::ColourW-1:0];
        default: ;
      endcase
    end
  end

  // divisor zero acts as one
  logic [shsp_pkg::DivW-1:0] div_eff;
  assign div_eff = (div_q == '0) ? shsp_pkg::DivW'(1) : div_q;

  // control state
  state_e                          state_q;
  logic [shsp_pkg::CntW-1:0]       fill_q;
  logic [shsp_pkg::AddrW-1:0]      newest_q, oldest_q, rd_ptr_q;
  logic [shsp_pkg::CntW-1:0]       col_q;
  logic [shsp_pkg::RecipW-1:0]     recip_q;
  logic [shsp_pkg::DivW-1:0]       rem_q;
  logic [shsp_pkg::RecipCntW-1:0]  bit_q;

  logic in_acc, adv, issue;
  logic v1_q, v2_q, v3_q, v4_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adv        = !out_valid_o || !out_stall_i;
  assign issue      = (state_q == StRun) && adv;

  // slot bookkeeping for the incoming sample
  logic [shsp_pkg::AddrW-1:0] slot_new, slot_after;
  logic [shsp_pkg::CntW-1:0]  fill_new;
  always_comb begin
    if (fill_q == '0) begin
      slot_new = newest_q;
    end else if (newest_q == LastSlot) begin
      slot_new = '0;
    end else begin
      slot_new = newest_q + shsp_pkg::AddrW'(1);
    end
    slot_after = (slot_new == LastSlot) ? '0 : slot_new + shsp_pkg::AddrW'(1);
    fill_new   = (fill_q == FullCnt) ? fill_q : fill_q + shsp_pkg::CntW'(1);
  end

  // one restoring step of 2^RecipK / d
  logic [shsp_pkg::DivW:0] rem_shift;
  logic                    rem_ge;
  always_comb begin
    rem_shift = {rem_q, (bit_q == shsp_pkg::RecipCntW'(shsp_pkg::RecipK))};
    rem_ge    = (rem_shift >= {1'b0, div_eff});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      rd_ptr_q <= '0;
      col_q    <= '0;
      recip_q  <= '0;
      rem_q    <= '0;
      bit_q    <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            newest_q <= slot_new;
            fill_q   <= fill_new;
            oldest_q <= (fill_new == FullCnt) ? slot_after : '0;
            rem_q    <= '0;
            recip_q  <= '0;
            bit_q    <= shsp_pkg::RecipCntW'(shsp_pkg::RecipK);
            state_q  <= StRecip;
          end
        end
        StRecip: begin
          recip_q <= {recip_q[shsp_pkg::RecipW-2:0], rem_ge};
          rem_q   <= rem_ge ? shsp_pkg::DivW'(rem_shift - {1'b0, div_eff})
                            : rem_shift[shsp_pkg::DivW-1:0];
          if (bit_q == '0) begin
            rd_ptr_q <= oldest_q;
            col_q    <= '0;
            state_q  <= StRun;
          end else begin
            bit_q <= bit_q - shsp_pkg::RecipCntW'(1);
          end
        end
        StRun: begin
          if (adv) begin
            rd_ptr_q <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + shsp_pkg::AddrW'(1);
            col_q    <= col_q + shsp_pkg::CntW'(1);
            if (col_q + shsp_pkg::CntW'(1) == fill_q) begin
              state_q <= StDrain;
            end
          end
        end
        StDrain: begin
          if (!v1_q && !v2_q && !v3_q && !v4_q) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // history memory, one write and one registered read port
  logic signed [shsp_pkg::SampleW-1:0] hist_mem [shsp_pkg::HistoryDepth];
  logic signed [shsp_pkg::SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hist_mem[slot_new] <= sample_value_i;
    end
    if (issue) begin
      rdata_q <= hist_mem[rd_ptr_q];
    end
  end

  // point pipeline, all stages advance together
  shsp_pkg::pt_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic                          neg2_q, neg3_q;
  logic [shsp_pkg::MagW-1:0]     mag1, mag2_q, mag3_q;
  logic [shsp_pkg::ProdW-1:0]    prod1;
  logic [shsp_pkg::QuotW-1:0]    qest2_q, qest3_q, qfix3;
  logic [shsp_pkg::QdW-1:0]      qd2, qd3_q, rem3;
  logic signed [shsp_pkg::QuotW:0] quot4_q;

  always_comb begin
    mag1  = rdata_q[shsp_pkg::SampleW-1] ? shsp_pkg::MagW'(-rdata_q)
                                          : shsp_pkg::MagW'(rdata_q);
    prod1 = mag1 * recip_q;
    qd2   = qest2_q * div_eff;
    rem3  = shsp_pkg::QdW'(mag3_q) - qd3_q;
    qfix3 = (rem3 >= shsp_pkg::QdW'(div_eff)) ? qest3_q + shsp_pkg::QuotW'(1) : qest3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl1_q.column <= col_q;
      ctl1_q.last   <= (col_q + shsp_pkg::CntW'(1) == fill_q);
      ctl2_q  <= ctl1_q;
      neg2_q  <= rdata_q[shsp_pkg::SampleW-1];
      mag2_q  <= mag1;
      qest2_q <= prod1[shsp_pkg::RecipK +: shsp_pkg::QuotW];
      ctl3_q  <= ctl2_q;
      neg3_q  <= neg2_q;
      mag3_q  <= mag2_q;
      qest3_q <= qest2_q;
      qd3_q   <= qd2;
      ctl4_q  <= ctl3_q;
      quot4_q <= neg3_q ? -$signed({1'b0, qfix3}) : $signed({1'b0, qfix3});
    end
  end

  // height, clamp and screen position
  logic signed [shsp_pkg::HsumW-1:0] hsum;
  logic [shsp_pkg::HeightW-1:0]      hclamp;
  always_comb begin
    hsum = shsp_pkg::HsumW'(offset_q) + shsp_pkg::HsumW'(quot4_q);
    if (hsum > shsp_pkg::HsumW'(shsp_pkg::PlotCeiling)) begin
      hclamp = shsp_pkg::HeightW'(shsp_pkg::PlotCeiling);
    end else if (hsum < 0) begin
      hclamp = '0;
    end else begin
      hclamp = hsum[shsp_pkg::HeightW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      column_index_o <= shsp_pkg::ColumnW'(ctl4_q.column);
      plot_height_o  <= hclamp;
      pixel_x_o      <= origin_x_q + shsp_pkg::OriginXW'(ctl4_q.column);
      pixel_y_o      <= origin_y_q - shsp_pkg::OriginYW'(hclamp);
      pixel_colour_o <= colour_q;
      last_point_o   <= ctl4_q.last;
    end
  end

  // checks
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!v1_q && !v2_q && !v3_q && !v4_q))
    else $error("input ready while points are in flight");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCnt)
    else $error("fill count beyond history depth");

  a_height_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> plot_height_o <= shsp_pkg::HeightW'(shsp_pkg::PlotCeiling))
    else $error("plot height above ceiling");

  a_recip_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (recip_q != '0))
    else $error("reciprocal not formed before reads");

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (fill_q != '0 && col_q < fill_q))
    else $error("read issued outside the filled history");

endmodule

[sim/tb_sample_history_strip_plot_top.sv]
// Self-checking testbench for sample_history_strip_plot_top: directed and random samples.
`timescale 1ns / 1ps

module tb_sample_history_strip_plot_top;

  typedef struct packed {
    logic [shsp_pkg::ColumnW-1:0]  column;
    logic [shsp_pkg::HeightW-1:0]  height;
    logic [shsp_pkg::OriginXW-1:0] px;
    logic [shsp_pkg::OriginYW-1:0] py;
    logic [shsp_pkg::ColourW-1:0]  colour;
    logic                          last;
  } plot_point_t;

  typedef struct packed {
    logic [shsp_pkg::CfgIdxW-1:0]  index;
    logic [shsp_pkg::CfgDataW-1:0] data;
  } reg_write_t;

  localparam int MaxIdle     = 14;
  localparam int LongHold    = 600;
  localparam int DrainCycles = 32;
  localparam int PhaseItems  = 52;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [shsp_pkg::CfgIdxW-1:0]        cfg_index = '0;
  logic [shsp_pkg::CfgDataW-1:0]       cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [shsp_pkg::SampleW-1:0] sample_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [shsp_pkg::ColumnW-1:0]        column_index;
  logic [shsp_pkg::HeightW-1:0]        plot_height;
  logic [shsp_pkg::OriginXW-1:0]       pixel_x;
  logic [shsp_pkg::OriginYW-1:0]       pixel_y;
  logic [shsp_pkg::ColourW-1:0]        pixel_colour;
  logic                                last_point;

  // history and register copy of the predictor
  logic signed [shsp_pkg::SampleW-1:0] hist_mem [shsp_pkg::HistoryDepth];
  int                                  hist_count = 0;
  int                                  hist_newest = 0;
  logic [shsp_pkg::DivW-1:0]           cur_divisor = 8'd1;
  logic signed [shsp_pkg::OffsetW-1:0] cur_offset = '0;
  logic [shsp_pkg::OriginXW-1:0]       cur_origin_x = '0;
  logic [shsp_pkg::OriginYW-1:0]       cur_origin_y = 8'd40;
  logic [shsp_pkg::ColourW-1:0]        cur_colour = 3'd4;

  logic signed [shsp_pkg::SampleW-1:0] sample_queue[$];
  reg_write_t                          reg_writes[$];
  plot_point_t                         expected_points[$];

  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int          long_hold_req = 0;
  int          long_holds_done = 0;
  int          mismatches = 0;

  sample_history_strip_plot_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_value_i (sample_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .column_index_o (column_index),
    .plot_height_o  (plot_height),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_colour_o (pixel_colour),
    .last_point_o   (last_point)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_sample_history_strip_plot_top: FAIL");
    $finish;
  end

  // Store one sample and queue one point per stored sample, oldest first.
  task automatic predict_points(input logic signed [shsp_pkg::SampleW-1:0] sample);
    int oldest;
    int slot;
    int divisor;
    int height;
    plot_point_t pt;
    if (hist_count != 0) hist_newest = (hist_newest + 1) % shsp_pkg::HistoryDepth;
    hist_mem[hist_newest] = sample;
    if (hist_count < shsp_pkg::HistoryDepth) hist_count++;
    oldest = (hist_newest + shsp_pkg::HistoryDepth - (hist_count - 1))
             % shsp_pkg::HistoryDepth;
    divisor = (cur_divisor == 0) ? 1 : int'(cur_divisor);
    for (int k = 0; k < hist_count; k++) begin
      slot = (oldest + k) % shsp_pkg::HistoryDepth;
      // int division truncates toward zero
      height = int'(cur_offset) + int'(hist_mem[slot]) / divisor;
      if (height > shsp_pkg::PlotCeiling) height = shsp_pkg::PlotCeiling;
      if (height < 0) height = 0;
      pt.column = shsp_pkg::ColumnW'(k);
      pt.height = shsp_pkg::HeightW'(height);
      pt.px     = shsp_pkg::OriginXW'(int'(cur_origin_x) + k);
      pt.py     = shsp_pkg::OriginYW'(int'(cur_origin_y) - height);
      pt.colour = cur_colour;
      pt.last   = (k == hist_count - 1);
      expected_points.push_back(pt);
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    mismatches++;
  endtask

  // register write channel; the register copy follows each accepted write
  always @(posedge clk) begin : reg_writer
    reg_write_t w;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (shsp_pkg::cfg_reg_e'(cfg_index))
          shsp_pkg::RegDivisor: cur_divisor = cfg_data[shsp_pkg::DivW-1:0];
          shsp_pkg::RegOffset:  cur_offset = cfg_data[shsp_pkg::OffsetW-1:0];
          shsp_pkg::RegOriginX: cur_origin_x = cfg_data[shsp_pkg::OriginXW-1:0];
          shsp_pkg::RegOriginY: cur_origin_y = cfg_data[shsp_pkg::OriginYW-1:0];
          shsp_pkg::RegColour:  cur_colour = cfg_data[shsp_pkg::ColourW-1:0];
          default: ;
        endcase
      end
      if (cfg_valid && !cfg_ready) begin
        // hold the write until taken
      end else if (reg_writes.size() != 0) begin
        w = reg_writes.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= w.index;
        cfg_data  <= w.data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : sample_sender
    int unsigned gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      gap = gap_left;
      if (in_valid) begin
        predict_points(sample_value);
        gap = in_idle_on ? $urandom_range(0, MaxIdle) : 0;
      end
      if (gap == 0 && sample_queue.size() != 0) begin
        in_valid     <= 1'b1;
        sample_value <= sample_queue.pop_front();
        gap_left     <= 0;
      end else begin
        in_valid <= 1'b0;
        gap_left <= (gap != 0) ? gap - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin : point_receiver
    plot_point_t got;
    plot_point_t want;
    int unsigned hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      long_holds_done <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {column_index, plot_height, pixel_x, pixel_y, pixel_colour, last_point};
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point, expected none, got %p", $time, got);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (got.column != want.column) report_field("column_index", want.column, got.column);
          if (got.height != want.height) report_field("plot_height", want.height, got.height);
          if (got.px != want.px) report_field("pixel_x", want.px, got.px);
          if (got.py != want.py) report_field("pixel_y", want.py, got.py);
          if (got.colour != want.colour) report_field("pixel_colour", want.colour, got.colour);
          if (got.last != want.last) report_field("last_point", want.last, got.last);
        end
      end
      if (long_holds_done != long_hold_req) begin
        long_holds_done <= long_hold_req;
        hold_left <= LongHold - 1;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        hold = out_idle_on ? $urandom_range(0, MaxIdle) : 0;
        out_stall <= (hold != 0);
        hold_left <= (hold != 0) ? hold - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [shsp_pkg::CfgIdxW-1:0] index,
                           input logic [shsp_pkg::CfgDataW-1:0] data);
    reg_writes.push_back('{index, data});
    do @(negedge clk); while (reg_writes.size() != 0 || cfg_valid);
  endtask

  task automatic load_settings(input int divisor, input int offset, input int origin_x,
                               input int origin_y, input int colour);
    write_reg(shsp_pkg::RegDivisor, shsp_pkg::CfgDataW'(divisor));
    write_reg(shsp_pkg::RegOffset, shsp_pkg::CfgDataW'(offset & 8'hFF));
    write_reg(shsp_pkg::RegOriginX, shsp_pkg::CfgDataW'(origin_x));
    write_reg(shsp_pkg::RegOriginY, shsp_pkg::CfgDataW'(origin_y));
    write_reg(shsp_pkg::RegColour, shsp_pkg::CfgDataW'(colour));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_points.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // half full-range samples, half scaled to land mostly inside the plot
  function automatic logic signed [shsp_pkg::SampleW-1:0] draw_sample();
    int divisor;
    int span;
    divisor = (cur_divisor == 0) ? 1 : int'(cur_divisor);
    span = divisor * 45;
    if (span > 4095) span = 4095;
    if ($urandom_range(0, 1)) return shsp_pkg::SampleW'($urandom_range(0, 8191));
    return shsp_pkg::SampleW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin : stimulus
    int directed_a[] = '{0, 4095, -4096, 1, -1, 39, 40, 41};
    int directed_b[] = '{-4096, -150, -127, 4095, 0};
    int directed_c[] = '{4095, -4096, 2805, -255};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // register defaults after reset; sample extremes and heights around the ceiling
    foreach (directed_a[i]) sample_queue.push_back(shsp_pkg::SampleW'(directed_a[i]));
    wait_idle();

    // divisor zero passes samples through, columns wrap past 511, rows wrap below 0
    load_settings(0, 127, 511, 0, 7);
    foreach (directed_b[i]) sample_queue.push_back(shsp_pkg::SampleW'(directed_b[i]));
    wait_idle();

    // bits above each register's width dropped; unknown indexes ignored
    write_reg(shsp_pkg::RegDivisor, 9'h1FF);
    write_reg(shsp_pkg::RegOffset, 9'h1F6);
    write_reg(shsp_pkg::RegOriginX, 9'h000);
    write_reg(shsp_pkg::RegOriginY, 9'h1FF);
    write_reg(shsp_pkg::RegColour, 9'h1F8);
    for (int k = int'(shsp_pkg::RegColour) + 1; k < 2 ** shsp_pkg::CfgIdxW; k++)
      write_reg(shsp_pkg::CfgIdxW'(k), shsp_pkg::CfgDataW'($urandom_range(0, 511)));
    foreach (directed_c[i]) sample_queue.push_back(shsp_pkg::SampleW'(directed_c[i]));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings(1, -128, 0, 40, 0);
        1: load_settings(255, 127, 319, 239, 7);
        5: load_settings($urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom_range(0, 511));
        default: load_settings($urandom_range(1, 255), $urandom_range(0, 255),
                               $urandom_range(0, 319), $urandom_range(40, 239),
                               $urandom_range(0, 7));
      endcase
      in_idle_on  = (ph % 3 != 1) && (ph != 3);
      out_idle_on = (ph % 4 != 2);
      // receiver holds off while the sender keeps offering samples
      if (ph == 3) long_hold_req++;
      for (int i = 0; i < PhaseItems; i++) begin
        sample_queue.push_back(draw_sample());
        // sender pauses mid-phase until every point has come
        if (ph == 6 && i == PhaseItems / 2) wait_idle();
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("tb_sample_history_strip_plot_top: PASS");
    end else begin
      $display("tb_sample_history_strip_plot_top: FAIL");
    end
    $finish;
  end

endmodule
